@@ design/quaternion_to_rotation_matrix_assert.svh @@
// Assertion macros for the quaternion to rotation matrix block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

`ifndef SYNTH
`define QRM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrm assertion failed");
`define QRM_ASSERT_LAT(lbl, cause, effect, n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> ##n (effect)) \
    else $error("qrm latency assertion failed");
`else
`define QRM_ASSERT(lbl, prop)
`define QRM_ASSERT_LAT(lbl, cause, effect, n)
`endif

`endif

@@ design/qrm_pkg.sv @@
// Types, constants and rounding function for the quaternion to rotation matrix block.
package qrm_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = (2 * FRAC_BITS > PROD_W) ? 2 * FRAC_BITS + 2 : PROD_W + 2;
  localparam int HALF_SHIFT = FRAC_BITS - 1;
  localparam int SHR_W      = SUM_W - HALF_SHIFT;
  localparam int LATENCY    = 3;

  localparam logic signed [SUM_W-1:0] ONE_HALF   = SUM_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (FRAC_BITS - 2);
  localparam logic signed [SHR_W-1:0] SAT_MAX    = SHR_W'(32767);
  localparam logic signed [SHR_W-1:0] SAT_MIN    = SHR_W'(-32768);
  localparam int                      DIAG_MIN   = (FRAC_BITS >= 15) ? -32768 : -(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [DATA_W-1:0] qw;
    logic signed [DATA_W-1:0] qi;
    logic signed [DATA_W-1:0] qj;
    logic signed [DATA_W-1:0] qk;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
  } out_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] ww;
    logic signed [PROD_W-1:0] ii;
    logic signed [PROD_W-1:0] jj;
    logic signed [PROD_W-1:0] kk;
    logic signed [PROD_W-1:0] ij;
    logic signed [PROD_W-1:0] wk;
    logic signed [PROD_W-1:0] wj;
    logic signed [PROD_W-1:0] ik;
    logic signed [PROD_W-1:0] jk;
    logic signed [PROD_W-1:0] wi;
  } prod_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] s00;
    logic signed [SUM_W-1:0] s01;
    logic signed [SUM_W-1:0] s02;
    logic signed [SUM_W-1:0] s10;
    logic signed [SUM_W-1:0] s11;
    logic signed [SUM_W-1:0] s12;
    logic signed [SUM_W-1:0] s20;
    logic signed [SUM_W-1:0] s21;
    logic signed [SUM_W-1:0] s22;
  } sum_t;

  // Round half up at the output scale, then clamp to 16 bits.
  function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [SUM_W-1:0] p);
    logic signed [SUM_W-1:0] b;
    logic signed [SHR_W-1:0] r;
    b = p + ROUND_BIAS;
    r = SHR_W'(b >>> HALF_SHIFT);
    if (r > SAT_MAX) begin
      return DATA_W'(SAT_MAX);
    end else if (r < SAT_MIN) begin
      return DATA_W'(SAT_MIN);
    end else begin
      return DATA_W'(r);
    end
  endfunction

endpackage

@@ design/qrm_mul.sv @@
// Product stage: the ten component products of the quaternion.
module qrm_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_in,
  input  qrm_pkg::in_t   q_in,
  output logic           vld_out,
  output qrm_pkg::prod_t prod_out
);

  localparam int PW = qrm_pkg::PROD_W;

  logic           vld_r;
  qrm_pkg::prod_t prod_r;
  qrm_pkg::prod_t prod_nxt;

  always_comb begin
    prod_nxt.ww = PW'(q_in.qw) * PW'(q_in.qw);
    prod_nxt.ii = PW'(q_in.qi) * PW'(q_in.qi);
    prod_nxt.jj = PW'(q_in.qj) * PW'(q_in.qj);
    prod_nxt.kk = PW'(q_in.qk) * PW'(q_in.qk);
    prod_nxt.ij = PW'(q_in.qi) * PW'(q_in.qj);
    prod_nxt.wk = PW'(q_in.qw) * PW'(q_in.qk);
    prod_nxt.wj = PW'(q_in.qw) * PW'(q_in.qj);
    prod_nxt.ik = PW'(q_in.qi) * PW'(q_in.qk);
    prod_nxt.jk = PW'(q_in.qj) * PW'(q_in.qk);
    prod_nxt.wi = PW'(q_in.qw) * PW'(q_in.qi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      prod_r <= prod_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign prod_out = prod_r;

endmodule

@@ design/qrm_sum.sv @@
// Sum stage: matrix entries at double scale, with the half taken off the diagonal.
module qrm_sum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_in,
  input  qrm_pkg::prod_t prod_in,
  output logic           vld_out,
  output qrm_pkg::sum_t  sum_out
);

  localparam int SW = qrm_pkg::SUM_W;

  logic          vld_r;
  qrm_pkg::sum_t sum_r;
  qrm_pkg::sum_t sum_nxt;

  always_comb begin
    sum_nxt.s00 = SW'(prod_in.ww) + SW'(prod_in.ii) - qrm_pkg::ONE_HALF;
    sum_nxt.s01 = SW'(prod_in.ij) - SW'(prod_in.wk);
    sum_nxt.s02 = SW'(prod_in.wj) + SW'(prod_in.ik);
    sum_nxt.s10 = SW'(prod_in.wk) + SW'(prod_in.ij);
    sum_nxt.s11 = SW'(prod_in.ww) + SW'(prod_in.jj) - qrm_pkg::ONE_HALF;
    sum_nxt.s12 = SW'(prod_in.jk) - SW'(prod_in.wi);
    sum_nxt.s20 = SW'(prod_in.ik) - SW'(prod_in.wj);
    sum_nxt.s21 = SW'(prod_in.wi) + SW'(prod_in.jk);
    sum_nxt.s22 = SW'(prod_in.ww) + SW'(prod_in.kk) - qrm_pkg::ONE_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      sum_r <= sum_nxt;
    end
  end

  assign vld_out = vld_r;
  assign sum_out = sum_r;

endmodule

@@ design/qrm_rnd.sv @@
// Output stage: round, saturate and register the nine entries.
module qrm_rnd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  qrm_pkg::sum_t sum_in,
  output logic          vld_out,
  output qrm_pkg::out_t m_out
);

  logic          vld_r;
  qrm_pkg::out_t m_r;
  qrm_pkg::out_t m_nxt;

  always_comb begin
    m_nxt.m00 = qrm_pkg::rnd_sat(sum_in.s00);
    m_nxt.m01 = qrm_pkg::rnd_sat(sum_in.s01);
    m_nxt.m02 = qrm_pkg::rnd_sat(sum_in.s02);
    m_nxt.m10 = qrm_pkg::rnd_sat(sum_in.s10);
    m_nxt.m11 = qrm_pkg::rnd_sat(sum_in.s11);
    m_nxt.m12 = qrm_pkg::rnd_sat(sum_in.s12);
    m_nxt.m20 = qrm_pkg::rnd_sat(sum_in.s20);
    m_nxt.m21 = qrm_pkg::rnd_sat(sum_in.s21);
    m_nxt.m22 = qrm_pkg::rnd_sat(sum_in.s22);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      m_r <= m_nxt;
    end
  end

  assign vld_out = vld_r;
  assign m_out   = m_r;

endmodule

@@ design/quaternion_to_rotation_matrix.sv @@
// Top level: quaternion to 3x3 rotation matrix, three-stage pipeline.
//
// Usage:
//   Input: drive in_q (qw, qi, qj, qk, signed Q1.14) and raise start. A
//   transaction is taken at every rising edge where start is high and busy is
//   low. busy is always low, so a new quaternion may be given every cycle.
//   Output: out_valid is high for one cycle with the nine entries on out_m
//   (signed Q1.14, rounded half up and saturated to 16 bits).
//   Path: an accepted quaternion passes through the product registers, the sum
//   registers and the round/saturate output register before out_valid is set.
//   Throughput: one transaction per clock, as no stage has a stall or busy
//   state.
//   Reset: synchronous rst_n low clears all stage valid bits; transactions in
//   flight are dropped and no strobe follows.
//   The receiver has no stall input: every result must be taken in its
//   strobe cycle.
`include "quaternion_to_rotation_matrix_assert.svh"

module quaternion_to_rotation_matrix (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  qrm_pkg::in_t  in_q,
  output logic          out_valid,
  output qrm_pkg::out_t out_m
);

  logic           acc;
  logic           v1;
  logic           v2;
  qrm_pkg::prod_t prod;
  qrm_pkg::sum_t  sums;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  qrm_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (acc),
    .q_in     (in_q),
    .vld_out  (v1),
    .prod_out (prod)
  );

  qrm_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (v1),
    .prod_in (prod),
    .vld_out (v2),
    .sum_out (sums)
  );

  qrm_rnd u_rnd (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (v2),
    .sum_in  (sums),
    .vld_out (out_valid),
    .m_out   (out_m)
  );

  `QRM_ASSERT_LAT(a_latency_fwd, acc, out_valid, 3)
  `QRM_ASSERT(a_no_spurious, out_valid |-> $past(acc, qrm_pkg::LATENCY))
  `QRM_ASSERT(a_diag_floor, out_valid |-> ($signed(out_m.m00) >= qrm_pkg::DIAG_MIN &&
    $signed(out_m.m11) >= qrm_pkg::DIAG_MIN && $signed(out_m.m22) >= qrm_pkg::DIAG_MIN))

endmodule

@@ sim/qrm_matrix_check.sv @@
// Checker for the quaternion to rotation matrix block: predicts each matrix and compares it.
`timescale 1ns / 100ps

module qrm_matrix_check
  import qrm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_q,
  input  logic out_valid,
  input  out_t out_m,
  output int   mismatch_cnt,
  output int   matrices_pending
);

  typedef struct {
    in_t  quat;
    out_t matrix;
  } quat_matrix_t;

  localparam int MAT_W = $bits(out_t);

  quat_matrix_t expected_matrices[$];
  int           field_errors = 0;
  string        entry_name[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  // Round half up at output scale, then clamp to 16 bits.
  function automatic logic [DATA_W-1:0] round_entry(input longint p);
    longint r;
    r = (p + (longint'(1) <<< (FRAC_BITS - 2))) >>> (FRAC_BITS - 1);
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return DATA_W'(r);
  endfunction

  function automatic out_t rotation_from_quat(input in_t q);
    longint w, i, j, k, half_one;
    out_t   m;
    w        = q.qw;
    i        = q.qi;
    j        = q.qj;
    k        = q.qk;
    half_one = longint'(1) <<< (2 * FRAC_BITS - 1);
    m.m00 = round_entry(w * w + i * i - half_one);
    m.m01 = round_entry(i * j - w * k);
    m.m02 = round_entry(w * j + i * k);
    m.m10 = round_entry(w * k + i * j);
    m.m11 = round_entry(w * w + j * j - half_one);
    m.m12 = round_entry(j * k - w * i);
    m.m20 = round_entry(i * k - w * j);
    m.m21 = round_entry(w * i + j * k);
    m.m22 = round_entry(w * w + k * k - half_one);
    return m;
  endfunction

  always @(posedge clk) begin : watch
    quat_matrix_t       e;
    logic [MAT_W-1:0]   e_bits;
    logic [MAT_W-1:0]   a_bits;
    logic [DATA_W-1:0]  ev;
    logic [DATA_W-1:0]  av;
    if (rst_n) begin
      if (start && !busy) begin
        e.quat   = in_q;
        e.matrix = rotation_from_quat(in_q);
        expected_matrices.push_back(e);
      end
      if (out_valid) begin
        if (expected_matrices.size() == 0) begin
          field_errors++;
          if (field_errors <= 10) begin
            $display("[%0t] unexpected result transaction: %h", $time, out_m);
          end
        end else begin
          e      = expected_matrices.pop_front();
          e_bits = e.matrix;
          a_bits = out_m;
          for (int idx = 0; idx < 9; idx++) begin
            ev = e_bits[MAT_W-1-DATA_W*idx -: DATA_W];
            av = a_bits[MAT_W-1-DATA_W*idx -: DATA_W];
            if (av !== ev) begin
              field_errors++;
              if (field_errors <= 10) begin
                $display("[%0t] %s mismatch for q=(%0d,%0d,%0d,%0d): expected %0d got %0d",
                         $time, entry_name[idx], e.quat.qw, e.quat.qi, e.quat.qj, e.quat.qk,
                         $signed(ev), $signed(av));
              end
            end
          end
        end
      end
    end
    mismatch_cnt     <= field_errors;
    matrices_pending <= expected_matrices.size();
  end

endmodule

@@ sim/testbench.sv @@
// Testbench top for the quaternion to rotation matrix block: stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import qrm_pkg::*;

  localparam int RANDOM_QUATS = 1500;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_q;
  logic out_valid;
  out_t out_m;

  int   mismatch_cnt;
  int   matrices_pending;
  int   cycle_cnt = 0;
  bit   no_gaps = 1'b0;

  int   edge_vals[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};

  always #4 clk = ~clk;

  quaternion_to_rotation_matrix u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_q     (in_q),
    .out_valid(out_valid),
    .out_m    (out_m)
  );

  qrm_matrix_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_q            (in_q),
    .out_valid       (out_valid),
    .out_m           (out_m),
    .mismatch_cnt    (mismatch_cnt),
    .matrices_pending(matrices_pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_quat(input int w, input int i, input int j, input int k);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_q  <= '{qw: 16'(w), qi: 16'(i), qj: 16'(j), qk: 16'(k)};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp(input int mode);
    if (mode <= 5) begin
      return 16'($urandom_range(0, 32768) - 16384);
    end else if (mode <= 7) begin
      return 16'($urandom);
    end else begin
      return 16'(edge_vals[$urandom_range(0, 6)]);
    end
  endfunction

  initial begin
    int mode;
    int c[4];
    rst_n = 1'b0;
    start = 1'b0;
    in_q  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: axes, extremes, rounding ties, non-unit inputs
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, -16384, -16384, 16384);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(16384, 16384, -16384, -16384);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -8192, 8192, -8192);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(0, 64, 64, 0);
    send_quat(64, 0, 0, 64);
    send_quat(1, 1, 1, 1);
    send_quat(-1, -1, -1, -1);

    for (int n = 0; n < RANDOM_QUATS; n++) begin
      if ($urandom_range(0, 59) == 0) begin
        no_gaps = !no_gaps;
      end
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        // near one axis: small noise, one component at +/- one
        for (int m = 0; m < 4; m++) begin
          c[m] = int'($urandom_range(0, 255)) - 128;
        end
        c[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16384 : -16384;
      end else begin
        for (int m = 0; m < 4; m++) begin
          c[m] = int'($signed(rand_comp(mode)));
        end
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
    start <= 1'b0;

    while (matrices_pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_cnt == 0 && matrices_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
